// ===== design/wall_follower_maze_walker_unit_defines.svh =====
// Assertion macros for the maze walker top level.
`ifndef WALL_FOLLOWER_MAZE_WALKER_UNIT_DEFINES_SVH
`define WALL_FOLLOWER_MAZE_WALKER_UNIT_DEFINES_SVH

`ifndef SYNTHESIS

// Same-cycle implication, checked out of reset.
`define WFMW_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked out of reset.
`define WFMW_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`else

`define WFMW_ASSERT_IMP(lbl, ante, cons, msg)
`define WFMW_ASSERT_NXT(lbl, ante, cons, msg)

`endif

`endif

// ===== design/wfmw_pkg.sv =====
`default_nettype none

package wfmw_pkg;

    localparam int MAX_DIM_DEF   = 32;
    localparam int MAX_STEPS_DEF = 1024;

    localparam int CFG_W   = 6;
    localparam int FUNC_W  = 2;
    localparam int CIDX_W  = 10;
    localparam int POS_W   = 5;
    localparam int HEAD_W  = 2;

    localparam logic [CFG_W-1:0] CFG_DIM_RESET = 6'd17;

    localparam logic REG_WIDTH  = 1'b0;
    localparam logic REG_HEIGHT = 1'b1;

    localparam logic [FUNC_W-1:0] FUNC_LOAD  = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_START = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_STEP  = 2'd2;

    localparam logic [HEAD_W-1:0] HD_DOWN  = 2'd0;
    localparam logic [HEAD_W-1:0] HD_LEFT  = 2'd1;
    localparam logic [HEAD_W-1:0] HD_UP    = 2'd2;
    localparam logic [HEAD_W-1:0] HD_RIGHT = 2'd3;

    typedef struct packed {
        logic [FUNC_W-1:0] func;
        logic [CIDX_W-1:0] cell_index;
        logic              is_wall;
    } t_item;

    typedef struct packed {
        logic [POS_W-1:0]  row;
        logic [POS_W-1:0]  col;
        logic [HEAD_W-1:0] facing;
        logic              at_exit;
        logic              overflow;
        logic              no_entrance;
    } t_result;

endpackage

`default_nettype wire

// ===== design/wfmw_ram.sv =====
`default_nettype none

module wfmw_ram #(
    parameter int WIDTH = 1,
    parameter int DEPTH = 1024
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

// ===== design/wfmw_core.sv =====
`default_nettype none

module wfmw_core #(
    parameter int MAX_DIM   = wfmw_pkg::MAX_DIM_DEF,
    parameter int MAX_STEPS = wfmw_pkg::MAX_STEPS_DEF
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_item_vld,
    input  wire wfmw_pkg::t_item              i_item,
    output logic                              o_idle,
    input  wire logic [$clog2(MAX_DIM+1)-1:0] i_width,
    input  wire logic [$clog2(MAX_DIM+1)-1:0] i_height,
    input  wire logic                         i_res_ready,
    output logic                              o_res_vld,
    output wfmw_pkg::t_result                 o_res
);

    import wfmw_pkg::*;

    localparam int DIM_W  = $clog2(MAX_DIM);
    localparam int SZ_W   = $clog2(MAX_DIM + 1);
    localparam int CELLS  = MAX_DIM * MAX_DIM;
    localparam int AW     = $clog2(CELLS);
    localparam int STEP_W = $clog2(MAX_STEPS + 1);

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_SCAN = 3'd1;
    localparam logic [2:0] ST_RD_A = 3'd2;
    localparam logic [2:0] ST_DEC  = 3'd3;
    localparam logic [2:0] ST_OUT  = 3'd4;

    typedef struct packed {
        logic             blocked;
        logic [DIM_W-1:0] row;
        logic [DIM_W-1:0] col;
        logic [AW-1:0]    addr;
    } t_nb;

    function automatic t_nb f_nb(
        input logic [HEAD_W-1:0] hd,
        input logic [DIM_W-1:0]  row,
        input logic [DIM_W-1:0]  col,
        input logic [SZ_W-1:0]   wd,
        input logic [SZ_W-1:0]   ht
    );
        t_nb               res;
        logic [SZ_W-1:0]   nr;
        logic [SZ_W-1:0]   nc;
        logic              under;
        logic [2*SZ_W-1:0] prod;
        nr    = SZ_W'(row);
        nc    = SZ_W'(col);
        under = 1'b0;
        case (hd)
            HD_DOWN: begin
                nr = nr + SZ_W'(1);
            end
            HD_LEFT: begin
                under = (nc == '0);
                nc    = nc - SZ_W'(1);
            end
            HD_UP: begin
                under = (nr == '0);
                nr    = nr - SZ_W'(1);
            end
            HD_RIGHT: begin
                nc = nc + SZ_W'(1);
            end
            default: begin
                under = 1'b1;
            end
        endcase
        prod        = {{SZ_W{1'b0}}, nr} * {{SZ_W{1'b0}}, wd};
        res.blocked = under || (nr >= ht) || (nc >= wd);
        res.row     = DIM_W'(nr);
        res.col     = DIM_W'(nc);
        res.addr    = AW'(prod + (2*SZ_W)'(nc));
        return res;
    endfunction

    logic [2:0]        r_state, n_state;
    logic [DIM_W-1:0]  r_row, n_row;
    logic [DIM_W-1:0]  r_col, n_col;
    logic [HEAD_W-1:0] r_head, n_head;
    logic [STEP_W-1:0] r_steps, n_steps;
    logic              r_halt, n_halt;
    logic              r_noent, n_noent;
    logic [AW-1:0]     r_sk, n_sk;
    logic [SZ_W-1:0]   r_sr, n_sr;
    logic [DIM_W-1:0]  r_sc, n_sc;
    logic              r_ck_v, n_ck_v;
    logic [DIM_W-1:0]  r_ck_r, n_ck_r;
    logic [DIM_W-1:0]  r_ck_c, n_ck_c;
    logic              r_right_open, n_right_open;

    t_nb               nb_r;
    t_nb               nb_a;
    logic [SZ_W-1:0]   hm1;
    logic              active;
    logic              issuing;
    logic [STEP_W-1:0] steps_inc;
    logic              ram_we;
    logic [AW-1:0]     ram_raddr;
    logic              ram_rdata;

    assign nb_r      = f_nb(r_head + HEAD_W'(1), r_row, r_col, i_width, i_height);
    assign nb_a      = f_nb(r_head, r_row, r_col, i_width, i_height);
    assign hm1       = i_height - SZ_W'(1);
    assign active    = !r_halt && (SZ_W'(r_row) < hm1);
    assign steps_inc = (r_steps < STEP_W'(MAX_STEPS)) ? r_steps + STEP_W'(1) : r_steps;
    assign issuing   = (r_sr < i_height);
    assign ram_we    = i_item_vld && (i_item.func == FUNC_LOAD)
                       && (32'(i_item.cell_index) < CELLS);

    wfmw_ram #(
        .WIDTH (1),
        .DEPTH (CELLS)
    ) u_wall_map (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (AW'(i_item.cell_index)),
        .i_wdata (i_item.is_wall),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    always_comb begin
        case (r_state)
            ST_SCAN: ram_raddr = r_sk;
            ST_RD_A: ram_raddr = nb_a.addr;
            default: ram_raddr = nb_r.addr;
        endcase
    end

    always_comb begin
        n_state      = r_state;
        n_row        = r_row;
        n_col        = r_col;
        n_head       = r_head;
        n_steps      = r_steps;
        n_halt       = r_halt;
        n_noent      = r_noent;
        n_sk         = r_sk;
        n_sr         = r_sr;
        n_sc         = r_sc;
        n_ck_v       = r_ck_v;
        n_ck_r       = r_ck_r;
        n_ck_c       = r_ck_c;
        n_right_open = r_right_open;
        case (r_state)
            ST_IDLE: begin
                if (i_item_vld && (i_item.func == FUNC_START)) begin
                    n_head  = HD_DOWN;
                    n_steps = '0;
                    n_noent = 1'b0;
                    n_sk    = '0;
                    n_sr    = '0;
                    n_sc    = '0;
                    n_ck_v  = 1'b0;
                    n_state = ST_SCAN;
                end else if (i_item_vld && (i_item.func == FUNC_STEP)) begin
                    n_noent = 1'b0;
                    n_state = ST_OUT;
                    if (active) begin
                        n_steps = steps_inc;
                        if (steps_inc >= STEP_W'(MAX_STEPS)) begin
                            n_halt = 1'b1;
                        end else begin
                            n_state = ST_RD_A;
                        end
                    end
                end
            end
            ST_SCAN: begin
                if (r_ck_v && !ram_rdata) begin
                    n_row   = r_ck_r;
                    n_col   = r_ck_c;
                    n_halt  = 1'b0;
                    n_state = ST_OUT;
                end else if (!issuing) begin
                    n_row   = '0;
                    n_col   = '0;
                    n_halt  = 1'b1;
                    n_noent = 1'b1;
                    n_state = ST_OUT;
                end else begin
                    n_ck_v = 1'b1;
                    n_ck_r = DIM_W'(r_sr);
                    n_ck_c = r_sc;
                    n_sk   = r_sk + AW'(1);
                    if (SZ_W'(r_sc) == i_width - SZ_W'(1)) begin
                        n_sc = '0;
                        n_sr = r_sr + SZ_W'(1);
                    end else begin
                        n_sc = r_sc + DIM_W'(1);
                    end
                end
            end
            ST_RD_A: begin
                n_right_open = !nb_r.blocked && !ram_rdata;
                n_state      = ST_DEC;
            end
            ST_DEC: begin
                if (r_right_open) begin
                    n_head = r_head + HEAD_W'(1);
                    n_row  = nb_r.row;
                    n_col  = nb_r.col;
                end else if (!nb_a.blocked && !ram_rdata) begin
                    n_row = nb_a.row;
                    n_col = nb_a.col;
                end else begin
                    n_head = r_head + HEAD_W'(3);
                end
                n_state = ST_OUT;
            end
            ST_OUT: begin
                if (i_res_ready) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_row   <= '0;
            r_col   <= '0;
            r_head  <= HD_DOWN;
            r_steps <= '0;
            r_halt  <= 1'b1;
            r_noent <= 1'b0;
            r_ck_v  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_row   <= n_row;
            r_col   <= n_col;
            r_head  <= n_head;
            r_steps <= n_steps;
            r_halt  <= n_halt;
            r_noent <= n_noent;
            r_ck_v  <= n_ck_v;
        end
    end

    always_ff @(posedge i_clk) begin
        r_sk         <= n_sk;
        r_sr         <= n_sr;
        r_sc         <= n_sc;
        r_ck_r       <= n_ck_r;
        r_ck_c       <= n_ck_c;
        r_right_open <= n_right_open;
    end

    assign o_idle    = (r_state == ST_IDLE);
    assign o_res_vld = (r_state == ST_OUT) && i_res_ready;

    always_comb begin
        o_res.row         = POS_W'(r_row);
        o_res.col         = POS_W'(r_col);
        o_res.facing      = r_head;
        o_res.at_exit     = (SZ_W'(r_row) >= hm1);
        o_res.overflow    = (r_steps >= STEP_W'(MAX_STEPS));
        o_res.no_entrance = r_noent;
    end

endmodule

`default_nettype wire

// ===== design/wall_follower_maze_walker_unit.sv =====
// Channel      Direction  tdata (low bit up)                        tuser
// s_axis       in         cell_index[9:0], is_wall[10], zero pad    func[1:0]
// m_axis       out        row, col, facing, at_exit, overflow,      none
//                         no_entrance, zero pad
// cfg          in         i_cfg_wdata into register i_cfg_idx        none
//
// A load item gives no result and leaves the walker idle.
// A step item goes from acceptance through ST_RD_A and ST_DEC to ST_OUT, which writes the
// result register once the output slot is free, and straight to ST_OUT when the walker
// is halted, at the exit or hits the step limit; the single read port of the wall map sets
// this, with the right and ahead cells read one after the other.
// A start item reads one cell per cycle until it finds an open cell or the grid runs out.
// Reset is synchronous and active low; the wall map is not cleared.
// A result waiting on m_axis does not block acceptance of the next item.
`default_nettype none

`include "wall_follower_maze_walker_unit_defines.svh"

module wall_follower_maze_walker_unit #(
    parameter int MAX_DIM   = wfmw_pkg::MAX_DIM_DEF,
    parameter int MAX_STEPS = wfmw_pkg::MAX_STEPS_DEF
) (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       s_axis_tvalid,
    output logic                            s_axis_tready,
    input  wire logic [15:0]                s_axis_tdata,  // cell_index, is_wall
    input  wire logic [1:0]                 s_axis_tuser,  // func
    output logic                            m_axis_tvalid,
    input  wire logic                       m_axis_tready,
    output logic [15:0]                     m_axis_tdata,  // row, col, facing, at_exit,
                                                           // overflow, no_entrance
    input  wire logic                       i_cfg_we,
    input  wire logic                       i_cfg_idx,
    input  wire logic [wfmw_pkg::CFG_W-1:0] i_cfg_wdata
);

    import wfmw_pkg::*;

    localparam int SZ_W = $clog2(MAX_DIM + 1);

    logic [CFG_W-1:0] r_width;
    logic [CFG_W-1:0] r_height;
    logic [SZ_W-1:0]  w_used;
    logic [SZ_W-1:0]  h_used;
    t_item            item;
    logic             item_vld;
    logic             idle;
    logic             res_ready;
    logic             res_vld;
    t_result          res;
    logic             r_out_valid;
    t_result          r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width  <= CFG_DIM_RESET;
            r_height <= CFG_DIM_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_WIDTH:  r_width  <= i_cfg_wdata;
                REG_HEIGHT: r_height <= i_cfg_wdata;
                default:    r_width  <= r_width;
            endcase
        end
    end

    always_comb begin
        if (r_width == '0) begin
            w_used = SZ_W'(1);
        end else if (32'(r_width) > MAX_DIM) begin
            w_used = SZ_W'(MAX_DIM);
        end else begin
            w_used = SZ_W'(r_width);
        end
        if (r_height == '0) begin
            h_used = SZ_W'(1);
        end else if (32'(r_height) > MAX_DIM) begin
            h_used = SZ_W'(MAX_DIM);
        end else begin
            h_used = SZ_W'(r_height);
        end
    end

    assign item.func       = s_axis_tuser;
    assign item.cell_index = s_axis_tdata[CIDX_W-1:0];
    assign item.is_wall    = s_axis_tdata[CIDX_W];

    assign s_axis_tready = idle;
    assign item_vld      = s_axis_tvalid && s_axis_tready;
    assign res_ready     = !r_out_valid || m_axis_tready;

    wfmw_core #(
        .MAX_DIM   (MAX_DIM),
        .MAX_STEPS (MAX_STEPS)
    ) u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_item_vld  (item_vld),
        .i_item      (item),
        .o_idle      (idle),
        .i_width     (w_used),
        .i_height    (h_used),
        .i_res_ready (res_ready),
        .o_res_vld   (res_vld),
        .o_res       (res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (res_vld) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (res_vld) begin
            r_out <= res;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {1'b0, r_out.no_entrance, r_out.overflow, r_out.at_exit,
                            r_out.facing, r_out.col, r_out.row};

    `WFMW_ASSERT_IMP(a_res_slot_free, res_vld, !r_out_valid || m_axis_tready,
        "result written over an item not yet taken")

    `WFMW_ASSERT_NXT(a_load_stays_idle,
        item_vld && (s_axis_tuser == FUNC_LOAD), s_axis_tready,
        "load item left the walker busy")

    `WFMW_ASSERT_IMP(a_noent_home, res_vld && res.no_entrance,
        (res.row == '0) && (res.col == '0) && (res.facing == HD_DOWN) && !res.overflow,
        "failed start did not park the walker at the origin")

endmodule

`default_nettype wire

// ===== sim/wfmw_walk_checker.sv =====
`timescale 1ns / 1ps

module wfmw_walk_checker #(
    parameter int MAX_DIM   = wfmw_pkg::MAX_DIM_DEF,
    parameter int MAX_STEPS = wfmw_pkg::MAX_STEPS_DEF
) (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       s_axis_tvalid,
    input  wire logic                       s_axis_tready,
    input  wire logic [15:0]                s_axis_tdata,  // cell_index, is_wall
    input  wire logic [1:0]                 s_axis_tuser,  // func
    input  wire logic                       m_axis_tvalid,
    input  wire logic                       m_axis_tready,
    input  wire logic [15:0]                m_axis_tdata,  // row, col, facing, at_exit,
                                                           // overflow, no_entrance
    input  wire logic                       i_cfg_we,
    input  wire logic                       i_cfg_idx,
    input  wire logic [wfmw_pkg::CFG_W-1:0] i_cfg_wdata,
    output int                              o_fail_count,
    output int                              o_outstanding
);

    import wfmw_pkg::*;

    localparam int MAP_CELLS = MAX_DIM * MAX_DIM;

    bit                wall_bits [MAP_CELLS];
    int                pos_row;
    int                pos_col;
    logic [HEAD_W-1:0] heading;
    int                step_count;
    bit                halted;
    logic [CFG_W-1:0]  width_reg;
    logic [CFG_W-1:0]  height_reg;
    t_result           expected_q [$];
    int                mismatches = 0;

    function automatic int used_dim(input logic [CFG_W-1:0] raw);
        if (raw == 0) return 1;
        if (raw > MAX_DIM) return MAX_DIM;
        return int'(raw);
    endfunction

    function automatic int row_delta(input logic [HEAD_W-1:0] hd);
        case (hd)
            HD_DOWN: return 1;
            HD_UP:   return -1;
            default: return 0;
        endcase
    endfunction

    function automatic int col_delta(input logic [HEAD_W-1:0] hd);
        case (hd)
            HD_LEFT:  return -1;
            HD_RIGHT: return 1;
            default:  return 0;
        endcase
    endfunction

    // Anything outside the grid in use is treated as a wall.
    function automatic bit blocked(input int r, input int c);
        int w;
        int h;
        w = used_dim(width_reg);
        h = used_dim(height_reg);
        if (r < 0 || c < 0 || r >= h || c >= w) return 1'b1;
        if (r * w + c >= MAP_CELLS) return 1'b1;
        return wall_bits[r * w + c];
    endfunction

    function automatic t_result walker_report(input bit no_open);
        t_result res;
        res.row         = pos_row[POS_W-1:0];
        res.col         = pos_col[POS_W-1:0];
        res.facing      = heading;
        res.at_exit     = (pos_row >= used_dim(height_reg) - 1);
        res.overflow    = (step_count >= MAX_STEPS);
        res.no_entrance = no_open;
        return res;
    endfunction

    task automatic enter_maze();
        int w;
        int h;
        int k;
        bit found;
        w = used_dim(width_reg);
        h = used_dim(height_reg);
        k = 0;
        found = 1'b0;
        while (!found && k < w * h && k < MAP_CELLS) begin
            if (!wall_bits[k]) begin
                found = 1'b1;
            end else begin
                k++;
            end
        end
        heading = HD_DOWN;
        step_count = 0;
        if (found) begin
            pos_row = k / w;
            pos_col = k % w;
            halted = 1'b0;
        end else begin
            pos_row = 0;
            pos_col = 0;
            halted = 1'b1;
        end
        expected_q.push_back(walker_report(!found));
    endtask

    task automatic take_step();
        int h;
        int r;
        int c;
        logic [HEAD_W-1:0] rh;
        h = used_dim(height_reg);
        if (!halted && pos_row < h - 1) begin
            if (step_count < MAX_STEPS) step_count++;
            if (step_count >= MAX_STEPS) begin
                halted = 1'b1;
            end else begin
                rh = heading + 1'b1;
                r = pos_row;
                c = pos_col;
                if (!blocked(r + row_delta(rh), c + col_delta(rh))) begin
                    heading = rh;
                    pos_row = r + row_delta(rh);
                    pos_col = c + col_delta(rh);
                end else if (!blocked(r + row_delta(heading), c + col_delta(heading))) begin
                    pos_row = r + row_delta(heading);
                    pos_col = c + col_delta(heading);
                end else begin
                    heading = heading - 1'b1;
                end
            end
        end
        expected_q.push_back(walker_report(1'b0));
    endtask

    task automatic check_result(input logic [15:0] data);
        t_result got;
        t_result want;
        got.row         = data[4:0];
        got.col         = data[9:5];
        got.facing      = data[11:10];
        got.at_exit     = data[12];
        got.overflow    = data[13];
        got.no_entrance = data[14];
        if (expected_q.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) begin
                $display("%0t: result with nothing expected: row=%0d col=%0d facing=%0d",
                         $realtime, got.row, got.col, got.facing);
            end
            return;
        end
        want = expected_q.pop_front();
        if (got.row !== want.row || got.col !== want.col || got.facing !== want.facing ||
            got.at_exit !== want.at_exit || got.overflow !== want.overflow ||
            got.no_entrance !== want.no_entrance) begin
            mismatches++;
            if (mismatches <= 10) begin
                $display("%0t: mismatch: expected row=%0d col=%0d facing=%0d exit=%b ovf=%b ne=%b",
                         $realtime, want.row, want.col, want.facing, want.at_exit,
                         want.overflow, want.no_entrance);
                $display("%0t:           actual row=%0d col=%0d facing=%0d exit=%b ovf=%b ne=%b",
                         $realtime, got.row, got.col, got.facing, got.at_exit,
                         got.overflow, got.no_entrance);
            end
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            pos_row = 0;
            pos_col = 0;
            heading = HD_DOWN;
            step_count = 0;
            halted = 1'b1;
            width_reg = CFG_DIM_RESET;
            height_reg = CFG_DIM_RESET;
            expected_q.delete();
        end else begin
            if (m_axis_tvalid && m_axis_tready) check_result(m_axis_tdata);
            if (s_axis_tvalid && s_axis_tready) begin
                case (s_axis_tuser)
                    FUNC_LOAD: begin
                        if (int'(s_axis_tdata[CIDX_W-1:0]) < MAP_CELLS) begin
                            wall_bits[s_axis_tdata[CIDX_W-1:0]] = s_axis_tdata[CIDX_W];
                        end
                    end
                    FUNC_START: enter_maze();
                    FUNC_STEP:  take_step();
                    default: ;
                endcase
            end
            if (i_cfg_we) begin
                if (i_cfg_idx == REG_WIDTH) begin
                    width_reg = i_cfg_wdata;
                end else begin
                    height_reg = i_cfg_wdata;
                end
            end
        end
        o_outstanding <= expected_q.size();
        o_fail_count <= mismatches;
    end

endmodule

// ===== sim/tb_wall_follower_maze_walker_unit.sv =====
`timescale 1ns / 1ps

module tb_wall_follower_maze_walker_unit;

    import wfmw_pkg::*;

    localparam logic [FUNC_W-1:0] FUNC_UNUSED = 2'd3;
    localparam int IDLE_LIMIT  = 6000;
    localparam int ITEM_TARGET = 460;

    // Hand-drawn 3 x 4 maze, bit k is the wall bit of cell k. The walk through it
    // goes straight, turns left, goes straight, turns right and ends in the bottom row.
    localparam logic [11:0] HAND_MAZE = 12'b0000_1100_1101;

    logic               i_clk;
    logic               i_rst_n;
    logic               s_axis_tvalid;
    logic               s_axis_tready;
    logic [15:0]        s_axis_tdata;
    logic [1:0]         s_axis_tuser;
    logic               m_axis_tvalid;
    logic               m_axis_tready;
    logic [15:0]        m_axis_tdata;
    logic               i_cfg_we;
    logic               i_cfg_idx;
    logic [CFG_W-1:0]   i_cfg_wdata;

    int fail_count;
    int outstanding;
    int idle_cycles = 0;
    int stall_pct = 0;
    int maze_w = 17;
    int maze_h = 17;
    int sent_items = 0;
    int regular_items = 0;

    wall_follower_maze_walker_unit dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_wdata   (i_cfg_wdata)
    );

    wfmw_walk_checker u_walk_checker (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_wdata   (i_cfg_wdata),
        .o_fail_count  (fail_count),
        .o_outstanding (outstanding)
    );

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    initial begin
        m_axis_tready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (stall_pct > 0 && $urandom_range(0, 99) < stall_pct) begin
                m_axis_tready <= 1'b0;
                repeat ($urandom_range(1, 6)) @(posedge i_clk);
            end
            m_axis_tready <= 1'b1;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
                idle_cycles <= 0;
            end else begin
                idle_cycles <= idle_cycles + 1;
            end
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("Verification failed");
                $finish;
            end
        end
    end

    function automatic int dim_in_use(input logic [CFG_W-1:0] raw);
        if (raw == 0) return 1;
        if (raw > MAX_DIM_DEF) return MAX_DIM_DEF;
        return int'(raw);
    endfunction

    task automatic send_item(input logic [FUNC_W-1:0] fn, input logic [CIDX_W-1:0] idx,
                             input logic wall);
        if (stall_pct > 0 && $urandom_range(0, 99) < stall_pct) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser <= fn;
        s_axis_tdata <= {5'b0, wall, idx};
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        sent_items++;
    endtask

    // Loads give no result, so a wait follows the drain of outstanding results.
    task automatic settle();
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (outstanding != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    task automatic write_dims(input logic [CFG_W-1:0] w_raw, input logic [CFG_W-1:0] h_raw);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= REG_WIDTH;
        i_cfg_wdata <= w_raw;
        @(posedge i_clk);
        i_cfg_idx <= REG_HEIGHT;
        i_cfg_wdata <= h_raw;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        maze_w = dim_in_use(w_raw);
        maze_h = dim_in_use(h_raw);
    endtask

    task automatic load_maze(input int wall_pct);
        for (int k = 0; k < maze_w * maze_h; k++) begin
            send_item(FUNC_LOAD, k[CIDX_W-1:0], $urandom_range(0, 99) < wall_pct);
        end
    endtask

    task automatic walk_maze(input int n_steps, input bit noisy);
        int pick;
        for (int s = 0; s < n_steps; s++) begin
            pick = noisy ? $urandom_range(0, 99) : 99;
            if (pick < 4) begin
                send_item(FUNC_UNUSED, CIDX_W'($urandom), 1'($urandom));
            end else if (pick < 9) begin
                send_item(FUNC_LOAD, CIDX_W'($urandom_range(0, maze_w * maze_h - 1)),
                          $urandom_range(0, 3) == 0);
            end else if (pick < 11) begin
                send_item(FUNC_START, CIDX_W'($urandom), 1'($urandom));
            end else begin
                send_item(FUNC_STEP, CIDX_W'($urandom), 1'($urandom));
            end
        end
    endtask

    initial begin
        logic [CFG_W-1:0] w_raw;
        logic [CFG_W-1:0] h_raw;
        int kind;
        int mark;

        i_rst_n <= 1'b0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata <= '0;
        s_axis_tuser <= FUNC_LOAD;
        i_cfg_we <= 1'b0;
        i_cfg_idx <= REG_WIDTH;
        i_cfg_wdata <= '0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // The walker is halted until the first start, and an unused code does nothing.
        send_item(FUNC_STEP, '1, 1'b1);
        send_item(FUNC_UNUSED, '0, 1'b0);
        settle();

        // A zero size clamps to one cell: first a walled maze, then an open one.
        write_dims('0, '0);
        send_item(FUNC_LOAD, '0, 1'b1);
        send_item(FUNC_START, '0, 1'b0);
        send_item(FUNC_STEP, '0, 1'b0);
        send_item(FUNC_LOAD, '0, 1'b0);
        send_item(FUNC_START, '1, 1'b1);
        send_item(FUNC_STEP, '1, 1'b0);
        settle();

        write_dims(6'd3, 6'd4);
        for (int k = 0; k < 12; k++) send_item(FUNC_LOAD, k[CIDX_W-1:0], HAND_MAZE[k]);
        send_item(FUNC_START, '0, 1'b0);
        walk_maze(6, 1'b0);
        settle();

        // Only the top row is open, so the walker paces until the step limit halts it.
        stall_pct = 15;
        write_dims(6'd2, 6'd3);
        for (int k = 0; k < maze_w * maze_h; k++) begin
            send_item(FUNC_LOAD, k[CIDX_W-1:0], k >= maze_w);
        end
        send_item(FUNC_START, '0, 1'b0);
        walk_maze(wfmw_pkg::MAX_STEPS_DEF + 6, 1'b0);
        settle();

        stall_pct = 25;
        write_dims(6'd63, 6'd6);
        load_maze(25);
        send_item(FUNC_START, '0, 1'b0);
        walk_maze(60, 1'b1);

        while (regular_items < ITEM_TARGET) begin
            mark = sent_items;
            if (regular_items > ITEM_TARGET * 4 / 5) begin
                stall_pct = 0;
            end else begin
                case ($urandom_range(0, 2))
                    0:       stall_pct = 0;
                    1:       stall_pct = 12;
                    default: stall_pct = 35;
                endcase
            end
            kind = $urandom_range(0, 99);
            w_raw = CFG_W'($urandom_range(1, 8));
            h_raw = CFG_W'($urandom_range(1, 8));
            if (kind % 20 == 0) w_raw = '0;
            else if (kind % 20 == 1) w_raw = CFG_W'($urandom_range(33, 63));
            else if (kind % 20 == 2) w_raw = 6'd32;
            if (kind % 17 == 0) h_raw = '0;
            else if (kind % 17 == 1) h_raw = CFG_W'($urandom_range(33, 63));
            else if (kind % 17 == 2) h_raw = 6'd32;
            if (dim_in_use(w_raw) * dim_in_use(h_raw) > 64) begin
                if (dim_in_use(w_raw) >= dim_in_use(h_raw)) begin
                    h_raw = CFG_W'($urandom_range(1, 2));
                end else begin
                    w_raw = CFG_W'($urandom_range(1, 2));
                end
            end

            settle();
            write_dims(w_raw, h_raw);
            load_maze(kind < 8 ? 100 : $urandom_range(10, 55));
            // Some phases keep the old walker after a resize, possibly outside the grid.
            if (kind < 8 || kind >= 22) send_item(FUNC_START, CIDX_W'($urandom), 1'($urandom));
            walk_maze($urandom_range(3, 45), 1'b1);
            regular_items += sent_items - mark;
        end

        settle();
        repeat (20) @(posedge i_clk);
        if (fail_count == 0 && outstanding == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule

// ===== files.f =====
+incdir+design
design/wfmw_pkg.sv
design/wfmw_ram.sv
design/wfmw_core.sv
design/wall_follower_maze_walker_unit.sv
sim/wfmw_walk_checker.sv
sim/tb_wall_follower_maze_walker_unit.sv
